// ===== rtl/hrlpe_pkg.sv =====
// Shared types and constants of the HSV/RGB LED pulse encoder.
package hrlpe_pkg;

    // Input item: one LED colour
    typedef struct packed {
        logic       mode;
        logic [8:0] first_component;
        logic [7:0] second_component;
        logic [7:0] third_component;
        logic [9:0] led_index;
    } item_t;

    // Result item: one pulse code
    typedef struct packed {
        logic [9:0]  led_position;
        logic [1:0]  channel;
        logic [2:0]  bit_slot;
        logic [15:0] pulse_code;
        logic        last;
    } result_t;

    // Converted colour waiting for the serialiser
    typedef struct packed {
        logic [9:0]  led_position;
        logic [23:0] rgb;
    } colour_t;

    // Colour formats
    localparam logic MODE_RGB = 1'b0;
    localparam logic MODE_HSV = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_PULSE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_PULSE = 8'd1;

    // Queue between converter and serialiser
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Serialiser
    localparam int unsigned RESULTS_PER_ITEM = 24;
    localparam int unsigned SLOT_CNT_W       = $clog2(RESULTS_PER_ITEM);
    localparam logic [SLOT_CNT_W-1:0] LAST_SLOT = SLOT_CNT_W'(RESULTS_PER_ITEM - 1);

    // Reciprocal constants: floor(n/d) = (n * ceil(2^sh/d)) >> sh for the operand ranges used
    localparam int unsigned TOP_SHIFT = 22;   // n < 2^15, d = 100
    localparam int unsigned LOW_SHIFT = 36;   // n < 2^22, d = 10000
    localparam int unsigned MID_SHIFT = 48;   // n < 2^28, d = 600000
    localparam longint unsigned TOP_DIV = 100;
    localparam longint unsigned LOW_DIV = 10000;
    localparam longint unsigned MID_DIV = 600000;
    localparam logic [15:0] M_TOP =
        16'(((64'd1 << TOP_SHIFT) + TOP_DIV - 64'd1) / TOP_DIV);
    localparam logic [22:0] M_LOW =
        23'(((64'd1 << LOW_SHIFT) + LOW_DIV - 64'd1) / LOW_DIV);
    localparam logic [28:0] M_MID =
        29'(((64'd1 << MID_SHIFT) + MID_DIV - 64'd1) / MID_DIV);

endpackage

// ===== rtl/hrlpe_front.sv =====
// Front end: clamp, classify and convert each colour to 8-bit RGB over a four-stage pipeline.
module hrlpe_front
    import hrlpe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    output logic    out_valid,
    output colour_t out_colour
);

    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;

    typedef struct packed {
        logic        mode;
        logic [2:0]  sector;
        logic [23:0] raw_rgb;
        logic [9:0]  pos;
    } carry_t;

    // stage 0 (combinational on the accepted item)
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] val;
    logic [2:0] sector;
    logic [6:0] r120;
    logic [5:0] dev;
    logic [5:0] k;
    carry_t     carry0;

    always_comb
    begin
        hue = (item.first_component > 9'd360) ? 9'd360 : item.first_component;
        sat = (item.second_component > 8'd100) ? 7'd100 : item.second_component[6:0];
        val = (item.third_component > 8'd100) ? 7'd100 : item.third_component[6:0];

        if (hue < 9'd60)
            sector = SECTOR_0;
        else if (hue < 9'd120)
            sector = SECTOR_1;
        else if (hue < 9'd180)
            sector = SECTOR_2;
        else if (hue < 9'd240)
            sector = SECTOR_3;
        else if (hue < 9'd300)
            sector = SECTOR_4;
        else
            sector = SECTOR_5;

        if (hue >= 9'd360)
            r120 = 7'd0;
        else if (hue >= 9'd240)
            r120 = 7'(hue - 9'd240);
        else if (hue >= 9'd120)
            r120 = 7'(hue - 9'd120);
        else
            r120 = hue[6:0];

        dev = (r120 >= 7'd60) ? 6'(r120 - 7'd60) : 6'(7'd60 - r120);
        k   = 6'd60 - dev;

        carry0.mode    = item.mode;
        carry0.sector  = sector;
        carry0.raw_rgb = {item.first_component[7:0], item.second_component,
                          item.third_component};
        carry0.pos     = item.led_index;
    end

    // stage 1: clamped operands
    logic       s1_valid_reg;
    carry_t     s1_carry_reg;
    logic [6:0] s1_sat_reg;
    logic [6:0] s1_val_reg;
    logic [5:0] s1_k_reg;

    // stage 2: first products
    logic        s2_valid_reg;
    carry_t      s2_carry_reg;
    logic [6:0]  s2_val_reg;
    logic [14:0] s2_ntop_reg;
    logic [13:0] s2_vs_reg;
    logic [12:0] s2_w_reg;

    // stage 3: top done, low and mid numerators
    logic        s3_valid_reg;
    carry_t      s3_carry_reg;
    logic [7:0]  s3_top_reg;
    logic [21:0] s3_nlow_reg;
    logic [19:0] s3_p_reg;

    // stage 4: low done, mid numerator
    logic        s4_valid_reg;
    carry_t      s4_carry_reg;
    logic [7:0]  s4_top_reg;
    logic [7:0]  s4_low_reg;
    logic [27:0] s4_q_reg;

    logic [6:0]  s1_rest;
    logic [14:0] ntop_next;
    logic [13:0] vs_next;
    logic [12:0] w_next;
    logic [30:0] top_prod;
    logic [21:0] nlow_next;
    logic [19:0] p_next;
    logic [44:0] low_prod;
    logic [27:0] q_next;
    logic [56:0] mid_prod;
    logic [7:0]  mid;

    always_comb
    begin
        s1_rest   = 7'd100 - s1_sat_reg;
        ntop_next = (15'(s1_val_reg) << 8) - 15'(s1_val_reg);
        vs_next   = 14'(s1_val_reg) * 14'(s1_rest);
        w_next    = 13'(s1_sat_reg) * 13'(s1_k_reg)
                  + ((13'(s1_rest) << 6) - (13'(s1_rest) << 2));

        top_prod  = 31'(s2_ntop_reg) * 31'(M_TOP);
        nlow_next = (22'(s2_vs_reg) << 8) - 22'(s2_vs_reg);
        p_next    = 20'(s2_val_reg) * 20'(s2_w_reg);

        low_prod  = 45'(s3_nlow_reg) * 45'(M_LOW);
        q_next    = (28'(s3_p_reg) << 8) - 28'(s3_p_reg);

        mid_prod  = 57'(s4_q_reg) * 57'(M_MID);
        mid       = mid_prod[MID_SHIFT +: 8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_carry_reg <= carry0;
        s1_sat_reg   <= sat;
        s1_val_reg   <= val;
        s1_k_reg     <= k;

        s2_carry_reg <= s1_carry_reg;
        s2_val_reg   <= s1_val_reg;
        s2_ntop_reg  <= ntop_next;
        s2_vs_reg    <= vs_next;
        s2_w_reg     <= w_next;

        s3_carry_reg <= s2_carry_reg;
        s3_top_reg   <= top_prod[TOP_SHIFT +: 8];
        s3_nlow_reg  <= nlow_next;
        s3_p_reg     <= p_next;

        s4_carry_reg <= s3_carry_reg;
        s4_top_reg   <= s3_top_reg;
        s4_low_reg   <= low_prod[LOW_SHIFT +: 8];
        s4_q_reg     <= q_next;
    end

    // channel order by sector; RGB items pass straight through
    always_comb
    begin
        out_valid               = s4_valid_reg;
        out_colour.led_position = s4_carry_reg.pos;
        if (s4_carry_reg.mode == MODE_RGB)
            out_colour.rgb = s4_carry_reg.raw_rgb;
        else
        begin
            unique case (s4_carry_reg.sector)
                SECTOR_0: out_colour.rgb = {s4_top_reg, mid, s4_low_reg};
                SECTOR_1: out_colour.rgb = {mid, s4_top_reg, s4_low_reg};
                SECTOR_2: out_colour.rgb = {s4_low_reg, s4_top_reg, mid};
                SECTOR_3: out_colour.rgb = {s4_low_reg, mid, s4_top_reg};
                SECTOR_4: out_colour.rgb = {mid, s4_low_reg, s4_top_reg};
                default:  out_colour.rgb = {s4_top_reg, s4_low_reg, mid};
            endcase
        end
    end

endmodule

// ===== rtl/hrlpe_queue.sv =====
// Short colour queue between the converter and the serialiser.
module hrlpe_queue
    import hrlpe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  colour_t push_data,
    input  logic    pop,
    output colour_t pop_data,
    output logic    not_empty
);

    colour_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        fill_next = fill_reg + FILL_W'(push) - FILL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data  = entry_reg[rd_ptr_reg];
    assign not_empty = (fill_reg != '0);

    // credits upstream must keep the queue from overflowing
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fill_reg != FILL_FULL) || pop)
        else $error("colour queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> fill_reg != '0)
        else $error("colour queue underflow");

endmodule

// ===== rtl/hrlpe_back.sv =====
// Back end: serialise one queued colour into 24 pulse-code items, one per cycle.
module hrlpe_back
    import hrlpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  colour_t     q_data,
    input  logic [15:0] one_code,
    input  logic [15:0] zero_code,
    output logic        pop,
    output logic        result_strobe,
    output result_t     result
);

    logic                  active_reg;
    logic                  active_next;
    logic [SLOT_CNT_W-1:0] cnt_reg;
    logic [SLOT_CNT_W-1:0] cnt_next;
    logic [23:0]           shift_reg;
    logic [23:0]           shift_next;
    logic [9:0]            pos_reg;
    logic [9:0]            pos_next;
    logic                  at_last;

    always_comb
    begin
        at_last     = active_reg && (cnt_reg == LAST_SLOT);
        // load the next colour as the last bit of the current one goes out: no gap
        pop         = q_not_empty && (!active_reg || at_last);
        active_next = active_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        pos_next    = pos_reg;
        if (pop)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            shift_next  = q_data.rgb;
            pos_next    = q_data.led_position;
        end
        else if (at_last)
            active_next = 1'b0;
        else if (active_reg)
        begin
            cnt_next   = cnt_reg + 1'b1;
            shift_next = {shift_reg[22:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        pos_reg   <= pos_next;
    end

    always_comb
    begin
        result_strobe       = active_reg;
        result.led_position = pos_reg;
        result.channel      = cnt_reg[SLOT_CNT_W-1 -: 2];
        result.bit_slot     = cnt_reg[2:0];
        result.pulse_code   = shift_reg[23] ? one_code : zero_code;
        result.last         = at_last;
    end

    // the items of one colour come out back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !at_last) |=> active_reg && (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("serialiser broke off a colour");

    // a new colour always starts at the red channel's top bit
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> active_reg && (cnt_reg == '0))
        else $error("serialiser loaded without restarting");

endmodule

// ===== rtl/hsv_rgb_led_pulse_encoder_unit.sv =====
// Top level of the HSV/RGB LED pulse encoder.
//
// Each item accepted (start high while busy is low) is one LED colour, RGB or HSV
// (hue clamped to 360, saturation and value to 100). The converter pipeline turns
// it into 8-bit RGB over four stages, then a two-entry queue hands it to the
// serialiser, which emits 24 result items on consecutive cycles: red, green, blue,
// most significant bit first, each with the one-pulse or zero-pulse code and
// result.last set on the 24th. The serialiser sends one bit per cycle and takes
// the next colour only once the current one is out; when it is free, an accepted
// item passes the four converter stages and the queue on its way to the ports.
// Results are strobed for exactly one cycle and the receiver cannot stall them.
// busy rises when the queue plus the pipeline hold two items; a new item is
// therefore taken while an earlier one is still being streamed out. Write the
// pulse-code registers only while no item is in flight.
module hsv_rgb_led_pulse_encoder_unit
    import hrlpe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  item_t                  item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    output logic                   result_strobe,
    output result_t                result
);

    localparam logic [FILL_W-1:0] CREDIT_FULL = FILL_W'(QUEUE_DEPTH);

    logic [15:0]       one_code_reg;
    logic [15:0]       zero_code_reg;
    logic [FILL_W-1:0] credit_reg;
    logic [FILL_W-1:0] credit_next;
    logic              accept;
    logic              fe_valid;
    colour_t           fe_colour;
    logic              pop;
    logic              q_not_empty;
    colour_t           q_data;

    // Register writes are always taken; indexes beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_code_reg  <= '0;
            zero_code_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ONE_PULSE:  one_code_reg  <= cfg_data;
                REG_ZERO_PULSE: zero_code_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Count items between acceptance and leaving the queue, so every item in the
    // converter pipeline is sure of a queue slot when it arrives.
    assign busy   = (credit_reg == CREDIT_FULL);
    assign accept = start && !busy;

    always_comb
    begin
        credit_next = credit_reg + FILL_W'(accept) - FILL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            credit_reg <= '0;
        else
            credit_reg <= credit_next;
    end

    hrlpe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .out_valid  (fe_valid),
        .out_colour (fe_colour)
    );

    hrlpe_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fe_valid),
        .push_data (fe_colour),
        .pop       (pop),
        .pop_data  (q_data),
        .not_empty (q_not_empty)
    );

    hrlpe_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_data        (q_data),
        .one_code      (one_code_reg),
        .zero_code     (zero_code_reg),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

    // items in flight never exceed the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CREDIT_FULL)
        else $error("credit count above queue depth");

    // a colour leaving the queue must have been counted in
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> credit_reg != '0)
        else $error("queue pop with no item in flight");

    // after the last item of a colour, either silence or a fresh colour from red bit 7
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |=>
            !result_strobe || (result.channel == 2'd0 && result.bit_slot == 3'd0))
        else $error("results of a colour not followed by a clean start");

endmodule
